FILE: rtl/core/bgc_pkg.sv
package bgc_pkg;

  localparam int unsigned NumButtons = 8;
  localparam int unsigned NumEncoders = 4;
  localparam int unsigned TimeBits = 32;
  localparam int unsigned BtnIdxW = $clog2(NumButtons);

  localparam logic [31:0] LongPressReset = 32'd500000;
  localparam logic [31:0] DoublePressReset = 32'd300000;
  localparam logic [31:0] ChordReset = 32'd50000;

  typedef enum logic [1:0] {
    CfgLongPress = 2'd0,
    CfgDoublePress = 2'd1,
    CfgChord = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeButton = 2'd0,
    ModeFlush = 2'd1,
    ModeEncoder = 2'd2,
    ModeClear = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    EvPress = 3'd0,
    EvDouble = 3'd1,
    EvLong = 3'd2,
    EvChord = 3'd3,
    EvTurn = 3'd4,
    EvHoldTurn = 3'd5
  } event_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] button_index;
    logic button_pressed;
    logic [31:0] sample_time;
    logic [31:0] now_time;
    logic [1:0] encoder_index;
    logic signed [15:0] encoder_delta;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [2:0] primary_button;
    logic [7:0] button_set;
    logic [1:0] encoder_number;
    logic signed [15:0] turn_amount;
    logic [31:0] event_time;
    logic last_of_run;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the input item
    logic button;    // run the button update on the captured item
    logic chord;     // chord check and record
    logic flush_step;// examine flush cursor button
    logic encoder;   // encoder event
    logic clear;     // drop pending presses
    logic emit_pop;  // oldest queued result taken
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic flush_last;
    logic queue_empty;
    logic queue_one;
  } status_t;

endpackage

FILE: rtl/core/bgc_ctrl.sv
module bgc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bgc_pkg::status_t status_i,
  output bgc_pkg::cmd_t    cmd_o
);
  import bgc_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StExec  = 5'b00010,
    StChord = 5'b00100,
    StFlush = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit) && !status_i.queue_empty;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StExec;
        end
      end
      StExec: begin
        case (status_i.mode)
          ModeButton: begin
            cmd_o.button = 1'b1;
            state_d = StChord;
          end
          ModeFlush: state_d = StFlush;
          ModeEncoder: begin
            cmd_o.encoder = 1'b1;
            state_d = StEmit;
          end
          default: begin
            cmd_o.clear = 1'b1;
            state_d = StEmit;
          end
        endcase
      end
      StChord: begin
        cmd_o.chord = 1'b1;
        state_d = StEmit;
      end
      StFlush: begin
        cmd_o.flush_step = 1'b1;
        if (status_i.flush_last) state_d = StEmit;
      end
      StEmit: begin
        if (status_i.queue_empty) begin
          state_d = StIdle;
        end else if (out_ready_i) begin
          cmd_o.emit_pop = 1'b1;
          if (status_i.queue_one) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/bgc_datapath.sv
module bgc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  bgc_pkg::in_item_t   in_item_i,
  input  bgc_pkg::cmd_t       cmd_i,
  output bgc_pkg::status_t    status_o,
  output bgc_pkg::out_item_t  out_item_o
);
  import bgc_pkg::*;

  localparam int unsigned QCntW = $clog2(NumButtons + 1);

  logic [31:0] long_q, dbl_q, chord_t_q;
  in_item_t item_q;

  logic [NumButtons-1:0] down_q, long_sent_q, await_q, chord_valid_q;
  logic [TimeBits-1:0] change_q [NumButtons];
  logic [TimeBits-1:0] release_q [NumButtons];
  logic [NumButtons-1:0] chord_mask_q [NumButtons];
  logic [NumButtons-1:0] held_q, pending_q;
  logic [BtnIdxW-1:0] cursor_q;

  // Result queue; written and read in order, at most NumButtons entries per item.
  out_item_t queue_q [NumButtons];
  logic [BtnIdxW-1:0] rd_q, wr_q;
  logic [QCntW-1:0] cnt_q;

  logic [BtnIdxW-1:0] id, fi;
  logic [NumButtons-1:0] bit_id, bit_fi;
  logic id_ok;
  logic [TimeBits-1:0] now_t, dt_rel, dt_chg, dt_age, dt_frel;
  logic [QCntW-1:0] held_cnt;
  logic chord_active, chord_free;
  logic [BtnIdxW-1:0] free_idx;
  logic push;
  out_item_t push_item;

  assign id = item_q.button_index[BtnIdxW-1:0];
  assign id_ok = ({29'd0, item_q.button_index} < 32'(NumButtons));
  assign bit_id = NumButtons'(1) << id;
  assign fi = cursor_q;
  assign bit_fi = NumButtons'(1) << fi;
  assign now_t = item_q.now_time[TimeBits-1:0];
  assign dt_rel = now_t - release_q[id];
  assign dt_chg = now_t - change_q[id];
  assign dt_age = now_t - item_q.sample_time[TimeBits-1:0];
  assign dt_frel = now_t - release_q[fi];

  always_comb begin
    held_cnt = '0;
    chord_active = 1'b0;
    chord_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < NumButtons; i++) begin
      held_cnt = held_cnt + QCntW'(held_q[i]);
      if (chord_valid_q[i] && chord_mask_q[i] == held_q) chord_active = 1'b1;
    end
    for (int i = NumButtons - 1; i >= 0; i--) begin
      if (!chord_valid_q[i]) begin
        chord_free = 1'b1;
        free_idx = BtnIdxW'(i);
      end
    end
  end

  // Decide whether the current command writes a result.
  always_comb begin
    push = 1'b0;
    push_item = '0;
    push_item.event_time = item_q.now_time;
    push_item.primary_button = item_q.button_index;
    push_item.button_set = 8'(bit_id);
    if (cmd_i.button && id_ok) begin
      if (item_q.button_pressed != down_q[id]) begin
        if (item_q.button_pressed && await_q[id] && dt_rel <= dbl_q[TimeBits-1:0]) begin
          push = 1'b1;
          push_item.event_kind = EvDouble;
        end
      end else if (item_q.button_pressed && !long_sent_q[id] &&
                   dt_chg >= long_q[TimeBits-1:0]) begin
        push = 1'b1;
        push_item.event_kind = EvLong;
      end
    end
    if (cmd_i.chord && id_ok && item_q.button_pressed && held_cnt >= QCntW'(2) &&
        !chord_active && dt_age <= chord_t_q[TimeBits-1:0]) begin
      push = 1'b1;
      push_item.event_kind = EvChord;
      push_item.button_set = 8'(held_q);
    end
    if (cmd_i.flush_step && pending_q[fi] && !long_sent_q[fi] &&
        !(await_q[fi] && dt_frel <= dbl_q[TimeBits-1:0])) begin
      push = 1'b1;
      push_item.event_kind = EvPress;
      push_item.primary_button = 3'(fi);
      push_item.button_set = 8'(bit_fi);
    end
    if (cmd_i.encoder && {30'd0, item_q.encoder_index} < 32'(NumEncoders) &&
        item_q.encoder_delta != '0) begin
      push = 1'b1;
      push_item.primary_button = '0;
      push_item.encoder_number = item_q.encoder_index;
      push_item.turn_amount = item_q.encoder_delta;
      push_item.button_set = 8'(held_q);
      push_item.event_kind = (held_q != '0) ? EvHoldTurn : EvTurn;
    end
  end

  // A chord only fires on a press that changed state, so the chord step is
  // gated by a flag left by the button step.
  logic chord_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q <= LongPressReset;
      dbl_q <= DoublePressReset;
      chord_t_q <= ChordReset;
      down_q <= '0;
      long_sent_q <= '0;
      await_q <= '0;
      chord_valid_q <= '0;
      held_q <= '0;
      pending_q <= '0;
      cursor_q <= '0;
      rd_q <= '0;
      wr_q <= '0;
      cnt_q <= '0;
      chord_go_q <= 1'b0;
      for (int i = 0; i < NumButtons; i++) begin
        change_q[i] <= '0;
        release_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgLongPress: long_q <= cfg_data_i;
          CfgDoublePress: dbl_q <= cfg_data_i;
          CfgChord: chord_t_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        cursor_q <= '0;
        chord_go_q <= 1'b0;
      end
      if (cmd_i.clear) pending_q <= '0;
      if (cmd_i.button && id_ok) begin
        if (item_q.button_pressed != down_q[id]) begin
          down_q[id] <= item_q.button_pressed;
          change_q[id] <= now_t;
          if (item_q.button_pressed) begin
            held_q <= held_q | bit_id;
            chord_go_q <= 1'b1;
            if (await_q[id] && dt_rel <= dbl_q[TimeBits-1:0]) begin
              await_q[id] <= 1'b0;
              long_sent_q[id] <= 1'b1;
            end else begin
              long_sent_q[id] <= 1'b0;
              pending_q <= pending_q | bit_id;
            end
          end else begin
            held_q <= held_q & ~bit_id;
            release_q[id] <= now_t;
            await_q[id] <= !long_sent_q[id];
            for (int i = 0; i < NumButtons; i++) begin
              if (chord_valid_q[i] && (chord_mask_q[i] & bit_id) != '0) begin
                chord_valid_q[i] <= 1'b0;
              end
            end
          end
        end else if (item_q.button_pressed && !long_sent_q[id] &&
                     dt_chg >= long_q[TimeBits-1:0]) begin
          long_sent_q[id] <= 1'b1;
          await_q[id] <= 1'b0;
        end
      end
      if (cmd_i.chord && push && chord_go_q && chord_free) begin
        chord_valid_q[free_idx] <= 1'b1;
      end
      if (cmd_i.flush_step) begin
        cursor_q <= cursor_q + 1'b1;
        if (pending_q[fi] && !(await_q[fi] && dt_frel <= dbl_q[TimeBits-1:0])) begin
          await_q[fi] <= 1'b0;
          pending_q[fi] <= 1'b0;
        end
      end
      if (push && !(cmd_i.chord && !chord_go_q)) begin
        wr_q <= wr_q + 1'b1;
      end
      if (cmd_i.emit_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(push && !(cmd_i.chord && !chord_go_q))
               - QCntW'(cmd_i.emit_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    if (cmd_i.chord && push && chord_go_q && chord_free) begin
      chord_mask_q[free_idx] <= held_q;
    end
    if (push && !(cmd_i.chord && !chord_go_q)) queue_q[wr_q] <= push_item;
  end

  always_comb begin
    out_item_o = queue_q[rd_q];
    out_item_o.last_of_run = (cnt_q == QCntW'(1));
  end

  assign status_o.mode = item_q.mode;
  assign status_o.flush_last = (cursor_q == BtnIdxW'(NumButtons - 1));
  assign status_o.queue_empty = (cnt_q == '0);
  assign status_o.queue_one = (cnt_q == QCntW'(1));

endmodule

FILE: rtl/core/button_gesture_classifier_top.sv
// Button gesture classifier.
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one transaction per
// item: a button sample, an end-of-scan flush, an encoder delta or a clear.
// Output channel (out_valid_o/out_ready_i/out_item_o) delivers the gesture
// events caused by that item in order; last_of_run marks the final one.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered;
// the user must make them while the block is idle, which is not enforced.
// A button sample passes through the execute and chord steps before its
// events show, a flush steps through every button (one button examined per
// cycle), and an encoder or clear item through the execute step alone. An
// item with no events returns to ready after passing the emit state.
// Items are processed one at a time; the next is accepted after the last
// event of the previous one is taken. A stalled receiver holds the current
// event steady and blocks further input.
// Reset clears all button state, chord records and pending presses and
// loads the default timing registers.
module button_gesture_classifier_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bgc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bgc_pkg::out_item_t out_item_o
);
  import bgc_pkg::*;

  cmd_t cmd;
  status_t status;

  bgc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  bgc_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .in_item_i,
    .cmd_i(cmd), .status_o(status), .out_item_o
  );

endmodule

FILE: rtl/core/bgc_checker.sv
module bgc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bgc_pkg::out_item_t out_item_o
);
  import bgc_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while events pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted two items back to back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.last_of_run |=> !out_valid_o)
    else $error("event after last of run");

endmodule

bind button_gesture_classifier_top bgc_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_item_o
);
